>>> src/assert_macros.svh
// Assertion macros shared by the files that check their own logic.
// Defining NO_ASSERTIONS leaves every use empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The property holds at every clock edge outside reset.
`define TPP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// When the antecedent holds, the consequent holds in the next cycle.
`define TPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TPP_ASSERT(lbl, clk, rstn, prop)
`define TPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> src/tpp_pkg.sv
package tpp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int TIME_W    = 31;
  localparam int PROD_W    = 63;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TERM_W + 2;
  localparam int DIV_STAGES = TIME_W;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_TOO_SMALL    = 2'd1,
    ST_TOO_LARGE    = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_START_POSITION = 2'd0,
    CFG_END_POSITION   = 2'd1,
    CFG_FINAL_TIME     = 2'd2,
    CFG_CRUISE_SPEED   = 2'd3
  } cfg_idx_e;

  // Settings and the values derived from them once per configuration.
  typedef struct packed {
    logic signed [POS_W-1:0] start_position;
    logic signed [POS_W-1:0] end_position;
    logic [TIME_W-1:0]       final_time;
    logic [TIME_W-1:0]       cruise_speed;
    status_e                 status;
    logic [TIME_W-1:0]       tc;
    logic signed [POS_W-1:0] tf_minus_tc;
    logic                    down;
  } cfg_t;

  // Per-request side information that travels along the pipeline.
  typedef struct packed {
    status_e           status;
    logic              from_end;
    logic              cruise;
    logic [TIME_W-1:0] x;
    logic [TERM_W-1:0] cterm;
  } meta_t;

  // Restoring divider word: partial remainder and the numerator bits still to
  // come, which are replaced from the bottom by quotient bits.
  typedef struct packed {
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] low;
    meta_t             meta;
  } div_word_t;

  // One restoring division step; returns the new remainder and shift word.
  function automatic logic [2*TIME_W-1:0] div_step(input logic [TIME_W-1:0] rem,
                                                   input logic [TIME_W-1:0] low,
                                                   input logic [TIME_W-1:0] d);
    logic [TIME_W:0] trial;
    logic [TIME_W:0] diff;
    trial = {rem, low[TIME_W-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {diff[TIME_W-1:0], low[TIME_W-2:0], 1'b1};
    end else begin
      div_step = {trial[TIME_W-1:0], low[TIME_W-2:0], 1'b0};
    end
  endfunction

endpackage

>>> src/tpp_if.sv
interface tpp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tpp_pkg::POS_W-1:0]     sample_time;
  modport source (output valid, output sample_time, input ready);
  modport sink (input valid, input sample_time, output ready);
endinterface

interface tpp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tpp_pkg::POS_W-1:0]     position;
  logic [1:0]                           status;
  modport source (output valid, output position, output status, input ready);
  modport sink (input valid, input position, input status, output ready);
endinterface

>>> src/tpp_setup.sv
// Holds the settings and derives the blend time after reset and after every write.
module tpp_setup (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [tpp_pkg::POS_W-1:0]    cfg_data_i,
  output tpp_pkg::cfg_t                cfg_o,
  output logic                         busy_o
);

  localparam int TW    = tpp_pkg::TIME_W;
  localparam int PW    = tpp_pkg::POS_W;
  localparam int CNT_W = $clog2(TW);

  typedef enum logic [4:0] {
    SU_IDLE = 5'b00001,
    SU_CALC = 5'b00010,
    SU_EVAL = 5'b00100,
    SU_DIV  = 5'b01000,
    SU_FIN  = 5'b10000
  } su_state_e;

  su_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic signed [PW-1:0] start_q, end_q;
  logic [TW-1:0] tf_q, v_q;
  logic [PW-1:0] dist_q;
  logic [2*TW-1:0] vt_q;
  logic [TW-1:0] rem_q, low_q, tc_q;
  logic signed [PW-1:0] tmt_q;
  logic down_q;
  tpp_pkg::status_e status_q;

  logic signed [PW:0] diff;
  logic [PW-1:0] dist_d;
  logic [tpp_pkg::PROD_W-1:0] scaled, vt_w, num;
  logic [2*TW-1:0] step;
  logic [PW:0] tmt_d;

  always_comb begin
    diff   = {end_q[PW-1], end_q} - {start_q[PW-1], start_q};
    dist_d = (diff < 0) ? PW'(-diff) : PW'(diff);
    scaled = tpp_pkg::PROD_W'({dist_q, {tpp_pkg::FRAC_BITS{1'b0}}});
    vt_w   = tpp_pkg::PROD_W'(vt_q);
    num    = vt_w - scaled + tpp_pkg::PROD_W'(v_q >> 1);
    step   = tpp_pkg::div_step(rem_q, low_q, v_q);
    tmt_d  = {2'b00, tf_q} - {2'b00, low_q};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SU_IDLE: state_d = SU_IDLE;
      SU_CALC: state_d = SU_EVAL;
      SU_EVAL: begin
        if (scaled >= vt_w || (scaled << 1) < vt_w) begin
          state_d = SU_FIN;
        end else begin
          state_d = SU_DIV;
        end
      end
      SU_DIV: begin
        if (cnt_q == CNT_W'(TW - 1)) begin
          state_d = SU_FIN;
        end
      end
      SU_FIN: state_d = SU_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = SU_CALC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SU_CALC;
      cnt_q   <= '0;
      start_q <= '0;
      end_q   <= PW'(1) << tpp_pkg::FRAC_BITS;
      tf_q    <= TW'(1) << tpp_pkg::FRAC_BITS;
      v_q     <= (TW'(3) << tpp_pkg::FRAC_BITS) >> 1;
    end else begin
      state_q <= state_d;
      if (state_q == SU_DIV) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
      if (cfg_we_i) begin
        unique case (tpp_pkg::cfg_idx_e'(cfg_idx_i))
          tpp_pkg::CFG_START_POSITION: start_q <= cfg_data_i;
          tpp_pkg::CFG_END_POSITION:   end_q   <= cfg_data_i;
          tpp_pkg::CFG_FINAL_TIME:     tf_q    <= cfg_data_i[TW-1:0];
          tpp_pkg::CFG_CRUISE_SPEED:   v_q     <= cfg_data_i[TW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SU_CALC: begin
        dist_q <= dist_d;
        down_q <= diff < 0;
        vt_q   <= v_q * tf_q;
      end
      SU_EVAL: begin
        if (scaled >= vt_w) begin
          status_q <= tpp_pkg::ST_TOO_SMALL;
        end else if ((scaled << 1) < vt_w) begin
          status_q <= tpp_pkg::ST_TOO_LARGE;
        end else begin
          status_q <= tpp_pkg::ST_OK;
        end
        rem_q <= num[2*TW-1:TW];
        low_q <= num[TW-1:0];
      end
      SU_DIV: begin
        rem_q <= step[2*TW-1:TW];
        low_q <= step[TW-1:0];
      end
      SU_FIN: begin
        tc_q  <= (status_q == tpp_pkg::ST_OK) ? low_q : '0;
        tmt_q <= tmt_d[PW-1:0];
      end
      SU_IDLE: begin
      end
    endcase
  end

  always_comb begin
    cfg_o.start_position = start_q;
    cfg_o.end_position   = end_q;
    cfg_o.final_time     = tf_q;
    cfg_o.cruise_speed   = v_q;
    cfg_o.status         = status_q;
    cfg_o.tc             = tc_q;
    cfg_o.tf_minus_tc    = tmt_q;
    cfg_o.down           = down_q;
  end

  assign busy_o = (state_q != SU_IDLE);

endmodule

>>> src/tpp_div_stage.sv
// One stage of the pipelined restoring divider: one quotient bit per stage.
module tpp_div_stage (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [tpp_pkg::TIME_W-1:0]    divisor_i,
  input  tpp_pkg::div_word_t            word_i,
  output tpp_pkg::div_word_t            word_o
);

  localparam int TW = tpp_pkg::TIME_W;

  tpp_pkg::div_word_t word_d, word_q;
  logic [2*TW-1:0] step;

  always_comb begin
    step        = tpp_pkg::div_step(word_i.rem, word_i.low, divisor_i);
    word_d      = word_i;
    word_d.rem  = step[2*TW-1:TW];
    word_d.low  = step[TW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

>>> src/trapezoidal_profile_position.sv
// Trapezoidal velocity profile position generator. Each request carries one
// signed Q16.16 sample time and yields one position with a status code; the
// block takes a new request in every cycle while the skid slot is empty and
// the setup unit is idle, and passes each one through a 31-stage pipelined
// divider that forms the ramp velocity. An output register with a skid slot
// lets requests keep flowing while a finished result waits. After reset and
// after every configuration write the setup unit works out the blend time
// with an iterative divider, which it skips when the cruise speed is
// rejected; ready stays low meanwhile.
`include "assert_macros.svh"

module trapezoidal_profile_position (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tpp_in_if.sink                     sample_i,
  tpp_out_if.source                  result_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tpp_pkg::POS_W-1:0]  cfg_data_i
);

  localparam int TW   = tpp_pkg::TIME_W;
  localparam int PW   = tpp_pkg::POS_W;
  localparam int FB   = tpp_pkg::FRAC_BITS;
  localparam int NDIV = tpp_pkg::DIV_STAGES;
  // Input, classify, multiply, divider load, divider stages, multiply, term.
  localparam int NV   = 4 + NDIV + 2;

  localparam logic signed [tpp_pkg::SUM_W-1:0] POS_MAX =
    tpp_pkg::SUM_W'({1'b0, {(PW-1){1'b1}}});
  localparam logic signed [tpp_pkg::SUM_W-1:0] POS_MIN = -POS_MAX - 1;

  tpp_pkg::cfg_t cfg;
  logic busy;

  tpp_setup u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .busy_o     (busy)
  );

  // The whole pipeline moves together whenever the skid slot is empty.
  logic en;
  logic accept;
  logic [NV-1:0] vld_q;
  logic out_v_q, skid_v_q;

  assign en              = !skid_v_q;
  assign sample_i.ready  = en && !busy;
  assign accept          = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], accept};
    end
  end

  // Input register.
  logic signed [PW-1:0] t1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= sample_i.sample_time;
    end
  end

  // Classify the sample into accelerate, cruise or decelerate and form the
  // multiplier operand: t, 2t - tc, or final_time - t.
  logic signed [PW:0] t_x, tc_x, tmt_x, tf_x, seg_x;
  tpp_pkg::meta_t meta2_d, meta2_q;
  logic [PW-1:0] xy2_d, xy2_q;

  always_comb begin
    t_x     = {t1_q[PW-1], t1_q};
    tc_x    = {2'b00, cfg.tc};
    tmt_x   = {cfg.tf_minus_tc[PW-1], cfg.tf_minus_tc};
    tf_x    = {2'b00, cfg.final_time};
    seg_x   = '0;
    meta2_d = '0;
    xy2_d   = '0;
    meta2_d.status = tpp_pkg::ST_OK;
    priority if (t_x >= 0 && t_x <= tc_x) begin
      xy2_d = t_x[PW-1:0];
    end else if (t_x > tc_x && t_x <= tmt_x) begin
      seg_x          = (t_x <<< 1) - tc_x;
      xy2_d          = seg_x[PW-1:0];
      meta2_d.cruise = 1'b1;
    end else if (t_x > tmt_x && t_x <= tf_x) begin
      seg_x            = tf_x - t_x;
      xy2_d            = seg_x[PW-1:0];
      meta2_d.from_end = 1'b1;
    end else begin
      meta2_d.status = tpp_pkg::ST_OUT_OF_RANGE;
    end
    meta2_d.x = xy2_d[TW-1:0];
    if (cfg.status != tpp_pkg::ST_OK) begin
      meta2_d.status = cfg.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta2_q <= meta2_d;
      xy2_q   <= xy2_d;
    end
  end

  // Cruise speed times the operand.
  tpp_pkg::meta_t meta3_q;
  logic [tpp_pkg::PROD_W-1:0] p3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta3_q <= meta2_q;
      p3_q    <= cfg.cruise_speed * xy2_q;
    end
  end

  // Divider load: the ramp numerator gets half the divisor for rounding, and
  // the cruise term is finished here since it needs no division.
  logic [tpp_pkg::PROD_W-1:0] num4;
  logic [tpp_pkg::PROD_W:0] cr_sum;
  tpp_pkg::div_word_t word4_d, word4_q;

  always_comb begin
    num4             = p3_q + tpp_pkg::PROD_W'(cfg.tc >> 1);
    cr_sum           = {1'b0, p3_q} + ((tpp_pkg::PROD_W + 1)'(1) << FB);
    word4_d.rem      = num4[2*TW-1:TW];
    word4_d.low      = num4[TW-1:0];
    word4_d.meta     = meta3_q;
    word4_d.meta.cterm = tpp_pkg::TERM_W'(cr_sum >> (FB + 1));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      word4_q <= word4_d;
    end
  end

  // Ramp velocity round(V*x/tc), one quotient bit per stage.
  tpp_pkg::div_word_t dw [NDIV+1];

  assign dw[0] = word4_q;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    tpp_div_stage u_div_stage (
      .clk_i     (clk_i),
      .en_i      (en),
      .divisor_i (cfg.tc),
      .word_i    (dw[k]),
      .word_o    (dw[k+1])
    );
  end

  // Velocity times x gives twice the ramp distance in raw units.
  tpp_pkg::meta_t metam_q;
  logic [2*TW-1:0] prodm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      metam_q <= dw[NDIV].meta;
      prodm_q <= dw[NDIV].low * dw[NDIV].meta.x;
    end
  end

  // Select and round the distance travelled from the chosen endpoint.
  logic [2*TW:0] rp_sum;
  tpp_pkg::meta_t metar_q;
  logic [tpp_pkg::TERM_W-1:0] termr_d, termr_q;

  always_comb begin
    rp_sum  = {1'b0, prodm_q} + ((2*TW + 1)'(1) << FB);
    termr_d = metam_q.cruise ? metam_q.cterm : tpp_pkg::TERM_W'(rp_sum >> (FB + 1));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      metar_q <= metam_q;
      termr_q <= termr_d;
    end
  end

  // Final add from the start or end position, saturated to 32 bits. A
  // result is zero whenever the status reports a problem.
  logic signed [tpp_pkg::SUM_W-1:0] base_x, term_x, sum_x;
  logic signed [PW-1:0] base, pos_d;
  logic pv;

  always_comb begin
    base   = metar_q.from_end ? cfg.end_position : cfg.start_position;
    base_x = {{(tpp_pkg::SUM_W-PW){base[PW-1]}}, base};
    term_x = {2'b00, termr_q};
    if (metar_q.from_end ^ cfg.down) begin
      sum_x = base_x - term_x;
    end else begin
      sum_x = base_x + term_x;
    end
    priority if (metar_q.status != tpp_pkg::ST_OK) begin
      pos_d = '0;
    end else if (sum_x > POS_MAX) begin
      pos_d = POS_MAX[PW-1:0];
    end else if (sum_x < POS_MIN) begin
      pos_d = POS_MIN[PW-1:0];
    end else begin
      pos_d = sum_x[PW-1:0];
    end
  end

  assign pv = vld_q[NV-1];

  // Output register with a skid slot behind it.
  logic signed [PW-1:0] out_pos_q, skid_pos_q;
  tpp_pkg::status_e out_st_q, skid_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || result_o.ready) begin
      out_v_q  <= skid_v_q || pv;
      skid_v_q <= 1'b0;
    end else if (pv && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || result_o.ready) begin
      if (skid_v_q) begin
        out_pos_q <= skid_pos_q;
        out_st_q  <= skid_st_q;
      end else begin
        out_pos_q <= pos_d;
        out_st_q  <= metar_q.status;
      end
    end else if (en) begin
      skid_pos_q <= pos_d;
      skid_st_q  <= metar_q.status;
    end
  end

  assign result_o.valid    = out_v_q;
  assign result_o.position = out_pos_q;
  assign result_o.status   = out_st_q;

  // Any failure status carries a zero position.
  `TPP_ASSERT(a_err_pos_zero, clk_i, rst_ni, result_o.valid && result_o.status != tpp_pkg::ST_OK |-> result_o.position == '0)
  // A settings write takes the block out of service from the next cycle on.
  `TPP_ASSERT_NEXT(a_cfg_blocks, clk_i, rst_ni, cfg_we_i, !sample_i.ready)
  // The skid slot fills only behind a full, stalled output register.
  `TPP_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_v_q |-> out_v_q)
  // A good result only comes from an accepted cruise speed.
  `TPP_ASSERT(a_ok_needs_cfg, clk_i, rst_ni, result_o.valid && result_o.status == tpp_pkg::ST_OK |-> cfg.status == tpp_pkg::ST_OK)

endmodule

>>> dv/trapezoidal_profile_position_tb.sv
`timescale 1ns / 1ps

module trapezoidal_profile_position_tb;

  // Expected positions for the accepted sample times, worked out from a
  // private copy of the four profile registers.
  class profile_scoreboard;
    longint start_pos;
    longint end_pos;
    longint unsigned duration;
    longint unsigned speed;
    logic signed [tpp_pkg::POS_W-1:0] want_pos[$];
    tpp_pkg::status_e want_status[$];
    int unsigned errors;

    function new();
      start_pos = 0;
      end_pos = 64'sd1 << tpp_pkg::FRAC_BITS;
      duration = 64'd1 << tpp_pkg::FRAC_BITS;
      speed = (64'd3 << tpp_pkg::FRAC_BITS) >> 1;
      errors = 0;
    endfunction

    function void set_reg(tpp_pkg::cfg_idx_e idx, logic [tpp_pkg::POS_W-1:0] data);
      case (idx)
        tpp_pkg::CFG_START_POSITION: start_pos = longint'(signed'(data));
        tpp_pkg::CFG_END_POSITION: end_pos = longint'(signed'(data));
        tpp_pkg::CFG_FINAL_TIME: duration = longint'(data[tpp_pkg::TIME_W-1:0]);
        default: speed = longint'(data[tpp_pkg::TIME_W-1:0]);
      endcase
    endfunction

    // Position on an acceleration or deceleration parabola x away from the end.
    function longint unsigned parabola(longint unsigned x, longint unsigned tc);
      longint unsigned vel;
      if (tc == 0) return 0;
      vel = (speed * x + tc / 2) / tc;
      return (vel * x + (64'd1 << tpp_pkg::FRAC_BITS)) >> (tpp_pkg::FRAC_BITS + 1);
    endfunction

    function void note_request(logic signed [tpp_pkg::POS_W-1:0] sample);
      longint t, delta, tci, tfi, pos;
      longint unsigned span, scaled, vt, tc, term;
      bit down, from_end;
      tpp_pkg::status_e st;
      t = longint'(sample);
      delta = end_pos - start_pos;
      down = delta < 0;
      span = down ? -delta : delta;
      scaled = span << tpp_pkg::FRAC_BITS;
      vt = speed * duration;
      st = tpp_pkg::ST_OK;
      pos = 0;
      from_end = 0;
      term = 0;
      if (scaled >= vt) begin
        st = tpp_pkg::ST_TOO_SMALL;
      end else if ((scaled << 1) < vt) begin
        st = tpp_pkg::ST_TOO_LARGE;
      end else begin
        tc = (vt - scaled + speed / 2) / speed;
        tci = longint'(tc);
        tfi = longint'(duration);
        if (t >= 0 && t <= tci) begin
          term = parabola(t, tc);
        end else if (t > tci && t <= tfi - tci) begin
          term = (speed * longint'(2 * t - tci) + (64'd1 << tpp_pkg::FRAC_BITS))
                 >> (tpp_pkg::FRAC_BITS + 1);
        end else if (t > tfi - tci && t <= tfi) begin
          term = parabola(tfi - t, tc);
          from_end = 1;
        end else begin
          st = tpp_pkg::ST_OUT_OF_RANGE;
        end
        if (st == tpp_pkg::ST_OK) begin
          if (from_end) pos = down ? end_pos + longint'(term) : end_pos - longint'(term);
          else pos = down ? start_pos - longint'(term) : start_pos + longint'(term);
          if (pos > 64'sd2147483647) pos = 64'sd2147483647;
          if (pos < -64'sd2147483648) pos = -64'sd2147483648;
        end
      end
      want_pos.push_back(pos[tpp_pkg::POS_W-1:0]);
      want_status.push_back(st);
    endfunction

    function void check_result(logic signed [tpp_pkg::POS_W-1:0] pos, logic [1:0] st);
      logic signed [tpp_pkg::POS_W-1:0] ep;
      tpp_pkg::status_e es;
      if (want_pos.size() == 0) begin
        $display("%0t: unexpected result position=%0d status=%0d", $time, pos, st);
        errors++;
        return;
      end
      ep = want_pos.pop_front();
      es = want_status.pop_front();
      if (st !== es) begin
        $display("%0t: status mismatch expected=%s actual=%0d", $time, es.name(), st);
        errors++;
      end
      if (pos !== ep) begin
        $display("%0t: position mismatch expected=%0d actual=%0d", $time, ep, pos);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  // Long enough for a result to travel the full pipeline after its request.
  localparam int SETTLE_CYCLES = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = tpp_pkg::CFG_START_POSITION;
  logic [tpp_pkg::POS_W-1:0] cfg_data_i = '0;

  tpp_in_if sample_if ();
  tpp_out_if result_if ();

  profile_scoreboard board = new();

  // Idling of each side for the current phase: chance in a hundred.
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles = 0;
  int unsigned total_requests = 0;

  always #1 clk_i = ~clk_i;

  trapezoidal_profile_position DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_if.sink),
    .result_o  (result_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    sample_if.valid = 1'b0;
    sample_if.sample_time = '0;
    result_if.ready = 1'b0;
  end

  // The receiving side stalls at random and checks each result it takes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        board.check_result(result_if.position, result_if.status);
      end
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The watchdog counts cycles in which neither side moves a request.
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               board.want_pos.size());
      $display("** trapezoidal_profile_position: FAILED **");
      $finish;
    end
  end

  // Offers one sample time, possibly after an idle gap, and holds it until the
  // block takes it. Valid is left high so that back-to-back requests flow.
  task automatic send_sample(logic signed [tpp_pkg::POS_W-1:0] t);
    if ($urandom_range(99) < send_gap_pct) begin
      sample_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    sample_if.valid <= 1'b1;
    sample_if.sample_time <= t;
    do @(posedge clk_i); while (!sample_if.ready);
    board.note_request(t);
    total_requests++;
  endtask

  // Waits until every expected result has come back and the pipeline is empty,
  // so that the registers may be rewritten safely.
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (board.want_pos.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(tpp_pkg::cfg_idx_e idx, logic [tpp_pkg::POS_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    board.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Writes all four registers. The unused top bit of the 31-bit registers is
  // filled at random, since the block must ignore it.
  task automatic load_profile(longint sp, longint ep, longint unsigned tf,
                              longint unsigned vc);
    write_reg(tpp_pkg::CFG_START_POSITION, sp[tpp_pkg::POS_W-1:0]);
    write_reg(tpp_pkg::CFG_END_POSITION, ep[tpp_pkg::POS_W-1:0]);
    write_reg(tpp_pkg::CFG_FINAL_TIME, {1'($urandom), tf[tpp_pkg::TIME_W-1:0]});
    write_reg(tpp_pkg::CFG_CRUISE_SPEED, {1'($urandom), vc[tpp_pkg::TIME_W-1:0]});
    cfg_we_i <= 1'b0;
  endtask

  // Picks a random profile that passes both speed checks: the cruise speed
  // must lie above D/T and no higher than 2D/T.
  task automatic pick_valid_profile(output longint sp, output longint ep,
                                    output longint unsigned tf,
                                    output longint unsigned vc);
    longint unsigned span, lim, lo, hi;
    bit found;
    found = 0;
    while (!found) begin
      tf = longint'($urandom_range(32'h7fff_ffff, 1)) >> $urandom_range(30, 0);
      if (tf == 0) tf = 1;
      lim = tf << 15;
      if (lim > 64'hffff_ffff) lim = 64'hffff_ffff;
      span = {$urandom, $urandom} % lim;
      lo = ((span << tpp_pkg::FRAC_BITS) / tf) + 1;
      hi = (span << (tpp_pkg::FRAC_BITS + 1)) / tf;
      if (hi > 64'h7fff_ffff) hi = 64'h7fff_ffff;
      if (span == 0 || lo > hi) continue;
      vc = lo + ({$urandom, $urandom} % (hi - lo + 1));
      sp = longint'(signed'($urandom));
      ep = ($urandom_range(1)) ? sp + longint'(span) : sp - longint'(span);
      if (ep > 64'sd2147483647 || ep < -64'sd2147483648) begin
        ep = (ep > sp) ? sp - longint'(span) : sp + longint'(span);
      end
      found = (ep <= 64'sd2147483647 && ep >= -64'sd2147483648);
    end
  endtask

  // A sample time biased towards the profile window and its borders, with a
  // share of arbitrary values that are mostly out of range.
  function automatic logic signed [tpp_pkg::POS_W-1:0] pick_time();
    longint unsigned tf;
    int unsigned sel;
    tf = board.duration;
    sel = $urandom_range(99);
    if (sel < 75) return tpp_pkg::POS_W'({$urandom, $urandom} % (tf + 1));
    if (sel < 85) return tpp_pkg::POS_W'(longint'(tf) + $urandom_range(2) - 1);
    if (sel < 90) return tpp_pkg::POS_W'($urandom_range(1)) - 1;
    return $urandom;
  endfunction

  initial begin
    longint sp, ep;
    longint unsigned tf, vc;
    logic signed [tpp_pkg::POS_W-1:0] directed[$];
    int phase;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset profile: the borders of the window, the
    // blend points and the extremes of the sample time.
    directed = '{0, 1, 32'h0000_5555, 32'h0000_8000, 32'h0000_aaaa, 32'h0000_ffff,
                 32'h0001_0000, 32'h0001_0001, -1, 32'h8000_0000, 32'h7fff_ffff,
                 32'h5555_5555, 32'haaaa_aaaa};
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // Zero duration and a stopped cruise both fail the low speed check.
    load_profile(0, 64'sd65536, 0, 64'd98304);
    send_sample(0);
    send_sample(32'h0000_8000);
    drain();
    load_profile(-64'sd1000, 64'sd1000, 64'd65536, 0);
    send_sample(32'h0000_8000);
    drain();
    // Equal endpoints always fail one of the speed checks.
    load_profile(64'sd12345, 64'sd12345, 64'd65536, 64'd65536);
    send_sample(32'h0000_4000);
    drain();
    // Full swing downwards with the longest duration.
    load_profile(64'sd2147483647, -64'sd2147483648, 64'h7fff_ffff, 64'h3_0000);
    send_sample(0);
    send_sample(32'h3fff_ffff);
    send_sample(32'h7fff_ffff);
    drain();
    // Shortest duration at the top cruise speed; the blend time rounds to
    // nothing, so the parabolas vanish.
    load_profile(-64'sd2147483648, -64'sd2147483648 + 64'sd16384, 1, 64'h7fff_ffff);
    send_sample(0);
    send_sample(1);
    send_sample(2);
    drain();

    // Random phases; the idling scheme rotates from one phase to the next.
    phase = 0;
    while (total_requests < 1950) begin
      case (phase % 4)
        0: begin send_gap_pct = 0; recv_stall_pct = 0; end
        1: begin send_gap_pct = 73; recv_stall_pct = 0; end
        2: begin send_gap_pct = 0; recv_stall_pct = 73; end
        default: begin send_gap_pct = 6; recv_stall_pct = 6; end
      endcase
      if ($urandom_range(9) < 8) begin
        pick_valid_profile(sp, ep, tf, vc);
      end else begin
        // Arbitrary settings that mostly fail a speed check.
        sp = longint'(signed'($urandom));
        ep = longint'(signed'($urandom));
        tf = $urandom_range(32'h7fff_ffff, 0) >> $urandom_range(31, 0);
        vc = $urandom_range(32'h7fff_ffff, 0) >> $urandom_range(31, 0);
      end
      load_profile(sp, ep, tf, vc);
      repeat ($urandom_range(150, 40)) send_sample(pick_time());
      drain();
      phase++;
    end

    if (board.errors == 0) begin
      $display("** trapezoidal_profile_position: PASSED **");
    end else begin
      $display("** trapezoidal_profile_position: FAILED **");
    end
    $finish;
  end

endmodule
